// File: rtl/wang_tile_lightness_placer_unit_defines.svh
// ----------------------------------------------------------------------------
// Wang tile lightness placer - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef WANG_TILE_LIGHTNESS_PLACER_UNIT_DEFINES_SVH
`define WANG_TILE_LIGHTNESS_PLACER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define WTLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WTLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wtlp_pkg.sv
// ----------------------------------------------------------------------------
// Wang tile lightness placer - package
// Widths, command and register codes, and the distance unit result type.
// ----------------------------------------------------------------------------
`default_nettype none

package wtlp_pkg;

  localparam int MAX_TILES      = 16;
  localparam int TILE_BITS      = $clog2(MAX_TILES);
  localparam int TILE_CNT_BITS  = $clog2(MAX_TILES + 1);
  localparam int MAX_ROW_CELLS  = 256;
  localparam int COL_BITS       = $clog2(MAX_ROW_CELLS);
  localparam int ROW_CELL_BITS  = $clog2(MAX_ROW_CELLS + 1);
  localparam int ROW_BITS       = 16;
  localparam int CODE_BITS      = 4;
  localparam int EDGE_BITS      = 4 * CODE_BITS;
  localparam int LIGHT_BITS     = 16;
  localparam int CMD_BITS       = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // commands
  localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_PLACE   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILES_IN_USE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILES_PER_ROW = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_PER_GRID = 2'd2;

  // edge code fields within a packed table entry
  localparam int FIELD_LEFT  = 0;
  localparam int FIELD_RIGHT = 1;
  localparam int FIELD_PREV  = 2;
  localparam int FIELD_NEXT  = 3;

  typedef struct packed {
    logic [LIGHT_BITS-1:0] gap;
    logic                  closer;
  } dist_res_t;

endpackage

`default_nettype wire

// File: rtl/wtlp_dist_unit.sv
// ----------------------------------------------------------------------------
// Wang tile lightness placer - distance unit
// Absolute lightness difference and compare against the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_dist_unit (
  input  logic [wtlp_pkg::LIGHT_BITS-1:0] target,
  input  logic [wtlp_pkg::LIGHT_BITS-1:0] light,
  input  logic [wtlp_pkg::LIGHT_BITS-1:0] best_dist,
  input  logic                            found,
  output wtlp_pkg::dist_res_t             res
);

  logic [wtlp_pkg::LIGHT_BITS-1:0] diff;

  assign diff       = (target >= light) ? (target - light) : (light - target);
  // strict less-than keeps the lowest index on a tie
  assign res.gap    = diff;
  assign res.closer = !found || (diff < best_dist);

endmodule

`default_nettype wire

// File: rtl/wang_tile_lightness_placer_unit.sv
// ----------------------------------------------------------------------------
// Wang tile lightness placer - top level
// Raster-order Wang tile placement: per cell, picks the edge-compatible tile
// whose mean lightness is closest to the target.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | in_valid / in_ready      | command, tile_index, code_*_edge,
//           |                          | tile_lightness, target_lightness
//  output   | out_valid / out_ready    | tile_choice, no_match, row_end,
//           |                          | grid_end
//  config   | cfg_write_en             | cfg_index, cfg_wdata
//
//  Load, restart and unknown transactions complete in the accept cycle.
//  A place transaction passes through the neighbour fetches, the candidate
//  scan and write-back before the next accept: the tile table has one read
//  port, read once for each neighbour's codes and once per candidate by the
//  shared distance unit.
//  Synchronous active-high reset; tables and line buffer hold garbage until
//  loaded, position and left choice clear to zero, no clearing pass.
//  A finished result sits in the output register; a following transaction is
//  accepted meanwhile and only stalls at its own write-back if still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module wang_tile_lightness_placer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wtlp_pkg::CMD_BITS-1:0]       command,
  input  logic [wtlp_pkg::TILE_BITS-1:0]      tile_index,
  input  logic [wtlp_pkg::CODE_BITS-1:0]      code_left_edge,
  input  logic [wtlp_pkg::CODE_BITS-1:0]      code_right_edge,
  input  logic [wtlp_pkg::CODE_BITS-1:0]      code_prev_row_edge,
  input  logic [wtlp_pkg::CODE_BITS-1:0]      code_next_row_edge,
  input  logic [wtlp_pkg::LIGHT_BITS-1:0]     tile_lightness,
  input  logic [wtlp_pkg::LIGHT_BITS-1:0]     target_lightness,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wtlp_pkg::TILE_BITS-1:0]      tile_choice,
  output logic                                no_match,
  output logic                                row_end,
  output logic                                grid_end,
  // configuration
  input  logic                                cfg_write_en,
  input  logic [wtlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wtlp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  `include "wang_tile_lightness_placer_unit_defines.svh"

  localparam int CB = wtlp_pkg::CODE_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0; // accepting
  localparam logic [2:0] S_NEIGH = 3'd1; // left tile codes and line buffer back
  localparam logic [2:0] S_PREV  = 3'd2; // above tile codes back, first fetch
  localparam logic [2:0] S_SCAN  = 3'd3; // one candidate per cycle
  localparam logic [2:0] S_DONE  = 3'd4; // write-back and result

  logic [2:0] state;

  // configuration registers
  logic [wtlp_pkg::TILE_CNT_BITS-1:0] tiles_in_use;
  logic [wtlp_pkg::ROW_CELL_BITS-1:0] tiles_per_row;
  logic [wtlp_pkg::ROW_BITS-1:0]      rows_per_grid;

  // position and left neighbour
  logic [wtlp_pkg::COL_BITS-1:0]  column_position;
  logic [wtlp_pkg::ROW_BITS-1:0]  row_position;
  logic [wtlp_pkg::TILE_BITS-1:0] left_choice;

  // tile table and line buffer
  logic [wtlp_pkg::EDGE_BITS-1:0]  edge_code_table [wtlp_pkg::MAX_TILES];
  logic [wtlp_pkg::LIGHT_BITS-1:0] lightness_table [wtlp_pkg::MAX_TILES];
  logic [wtlp_pkg::TILE_BITS-1:0]  previous_row_choices [wtlp_pkg::MAX_ROW_CELLS];

  logic [wtlp_pkg::TILE_BITS-1:0]  tbl_raddr;
  logic [wtlp_pkg::EDGE_BITS-1:0]  tbl_edge;
  logic [wtlp_pkg::LIGHT_BITS-1:0] tbl_light;
  logic [wtlp_pkg::TILE_BITS-1:0]  lb_rdata;

  // per-cell working state
  logic [wtlp_pkg::LIGHT_BITS-1:0]    target;
  logic                               col_nz;
  logic                               row_nz;
  logic [CB-1:0]                      want_left;
  logic [CB-1:0]                      want_prev;
  logic [wtlp_pkg::TILE_CNT_BITS-1:0] cnt;
  logic                               pend;
  logic [wtlp_pkg::TILE_BITS-1:0]     pend_idx;
  logic                               found;
  logic [wtlp_pkg::TILE_BITS-1:0]     best;
  logic [wtlp_pkg::LIGHT_BITS-1:0]    best_dist;

  // derived limits
  logic [wtlp_pkg::TILE_CNT_BITS-1:0] n_tiles;
  logic [wtlp_pkg::ROW_CELL_BITS-1:0] width;
  logic [wtlp_pkg::ROW_BITS-1:0]      height;
  logic                               cell_row_end;
  logic                               cell_grid_end;

  logic in_fire;
  logic out_busy;
  logic issue;
  logic cand_match;
  wtlp_pkg::dist_res_t dres;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  assign n_tiles = (tiles_in_use > wtlp_pkg::TILE_CNT_BITS'(wtlp_pkg::MAX_TILES))
                   ? wtlp_pkg::TILE_CNT_BITS'(wtlp_pkg::MAX_TILES) : tiles_in_use;
  always_comb begin
    if (tiles_per_row == '0) begin
      width = wtlp_pkg::ROW_CELL_BITS'(1);
    end else if (tiles_per_row > wtlp_pkg::ROW_CELL_BITS'(wtlp_pkg::MAX_ROW_CELLS)) begin
      width = wtlp_pkg::ROW_CELL_BITS'(wtlp_pkg::MAX_ROW_CELLS);
    end else begin
      width = tiles_per_row;
    end
  end
  assign height = (rows_per_grid == '0) ? wtlp_pkg::ROW_BITS'(1) : rows_per_grid;

  // a position past a shrunken size counts as the last cell
  assign cell_row_end  = ({1'b0, column_position} + wtlp_pkg::ROW_CELL_BITS'(1)) >= width;
  assign cell_grid_end = cell_row_end &&
                         (({1'b0, row_position} + 17'd1) >= {1'b0, height});

  // one fetch per scan cycle while candidates remain
  assign issue = ((state == S_PREV) || (state == S_SCAN)) && (cnt < n_tiles);

  // table read address: left neighbour, then above neighbour, then candidates
  always_comb begin
    unique case (state)
      S_IDLE:  tbl_raddr = left_choice;
      S_NEIGH: tbl_raddr = lb_rdata;
      default: tbl_raddr = cnt[wtlp_pkg::TILE_BITS-1:0];
    endcase
  end

  // edge compatibility of the candidate whose entry is back this cycle
  assign cand_match =
    (!col_nz || (tbl_edge[wtlp_pkg::FIELD_LEFT*CB +: CB] == want_left)) &&
    (!row_nz || (tbl_edge[wtlp_pkg::FIELD_PREV*CB +: CB] == want_prev));

  wtlp_dist_unit u_dist (
    .target    (target),
    .light     (tbl_light),
    .best_dist (best_dist),
    .found     (found),
    .res       (dres)
  );

  // tile table: written by load transactions, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && (command == wtlp_pkg::CMD_LOAD)) begin
      edge_code_table[tile_index] <= {code_next_row_edge, code_prev_row_edge,
                                      code_right_edge, code_left_edge};
      lightness_table[tile_index] <= tile_lightness;
    end
    tbl_edge  <= edge_code_table[tbl_raddr];
    tbl_light <= lightness_table[tbl_raddr];
  end

  // line buffer of the row above, indexed by column
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && !out_busy) begin
      previous_row_choices[column_position] <= best;
    end
    lb_rdata <= previous_row_choices[column_position];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      column_position <= '0;
      row_position    <= '0;
      left_choice     <= '0;
      tiles_in_use    <= wtlp_pkg::TILE_CNT_BITS'(16);
      tiles_per_row   <= wtlp_pkg::ROW_CELL_BITS'(256);
      rows_per_grid   <= wtlp_pkg::ROW_BITS'(256);
      cnt             <= '0;
      pend            <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          wtlp_pkg::CFG_TILES_IN_USE:
            tiles_in_use <= cfg_wdata[wtlp_pkg::TILE_CNT_BITS-1:0];
          wtlp_pkg::CFG_TILES_PER_ROW:
            tiles_per_row <= cfg_wdata[wtlp_pkg::ROW_CELL_BITS-1:0];
          wtlp_pkg::CFG_ROWS_PER_GRID:
            rows_per_grid <= cfg_wdata[wtlp_pkg::ROW_BITS-1:0];
          default: ;
        endcase
      end

      // write-back refills the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (command == wtlp_pkg::CMD_PLACE) begin
              state <= S_NEIGH;
            end else if (command == wtlp_pkg::CMD_RESTART) begin
              column_position <= '0;
              row_position    <= '0;
            end
          end
        end
        S_NEIGH: begin
          cnt   <= '0;
          state <= S_PREV;
        end
        S_PREV, S_SCAN: begin
          pend <= issue;
          if (issue) begin
            cnt <= cnt + wtlp_pkg::TILE_CNT_BITS'(1);
          end
          if ((state == S_SCAN) && !issue) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!out_busy) begin
            out_valid   <= 1'b1;
            left_choice <= best;
            if (cell_row_end) begin
              column_position <= '0;
              row_position    <= cell_grid_end ? '0
                                 : row_position + wtlp_pkg::ROW_BITS'(1);
            end else begin
              column_position <= column_position + wtlp_pkg::COL_BITS'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx <= cnt[wtlp_pkg::TILE_BITS-1:0];
    end
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          target    <= target_lightness;
          col_nz    <= (column_position != '0);
          row_nz    <= (row_position != '0);
          found     <= 1'b0;
          best      <= '0;
          best_dist <= '0;
        end
      end
      S_NEIGH: want_left <= tbl_edge[wtlp_pkg::FIELD_RIGHT*CB +: CB];
      S_PREV:  want_prev <= tbl_edge[wtlp_pkg::FIELD_NEXT*CB +: CB];
      S_SCAN: begin
        if (pend && cand_match && dres.closer) begin
          found     <= 1'b1;
          best      <= pend_idx;
          best_dist <= dres.gap;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          tile_choice <= best;
          no_match    <= !found;
          row_end     <= cell_row_end;
          grid_end    <= cell_grid_end;
        end
      end
      default: ;
    endcase
  end

  // checks
  `WTLP_ASSERT_NOW(a_nomatch_tile0, out_valid && no_match, tile_choice == '0,
                   "no_match result with non-zero tile")
  `WTLP_ASSERT_NOW(a_grid_implies_row, out_valid && grid_end, row_end,
                   "grid_end without row_end")
  `WTLP_ASSERT_NOW(a_best_in_range, (state == S_DONE) && found, best < n_tiles,
                   "chosen tile outside tiles in use")
  `WTLP_ASSERT_NEXT(a_done_returns, (state == S_DONE) && !out_busy,
                    in_ready && out_valid, "write-back did not publish result")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Wang tile lightness placer - block testbench
// Drives load, place, restart and unused-command transactions into the placer
// over phases of grid and tile settings and varied idling on both channels.
// Each place transaction's tile choice and flags are predicted here and
// compared in order against what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_BITS       = wtlp_pkg::CMD_BITS;
  localparam int TILE_BITS      = wtlp_pkg::TILE_BITS;
  localparam int CODE_BITS      = wtlp_pkg::CODE_BITS;
  localparam int LIGHT_BITS     = wtlp_pkg::LIGHT_BITS;
  localparam int CFG_INDEX_BITS = wtlp_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS  = wtlp_pkg::CFG_DATA_BITS;
  localparam int MAX_TILES      = wtlp_pkg::MAX_TILES;
  localparam int MAX_ROW_CELLS  = wtlp_pkg::MAX_ROW_CELLS;

  // command and register codes the package leaves unnamed
  localparam logic [CMD_BITS-1:0]       CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam int PHASES        = 8;
  localparam int ITEMS_A_PHASE = 120;  // counted transactions per random phase
  localparam int DRAIN_SLACK   = 48;   // settle time after the last result, in cycles
  localparam int LONG_HOLD     = 300;  // receiver hold-off, in cycles

  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [TILE_BITS-1:0]  tile_index;
    logic [CODE_BITS-1:0]  left_code;
    logic [CODE_BITS-1:0]  right_code;
    logic [CODE_BITS-1:0]  above_code;  // faces the previous row
    logic [CODE_BITS-1:0]  below_code;  // faces the next row
    logic [LIGHT_BITS-1:0] tile_light;
    logic [LIGHT_BITS-1:0] target;
  } tile_txn_t;

  typedef struct packed {
    logic [TILE_BITS-1:0] tile;
    logic                 no_match;
    logic                 row_end;
    logic                 grid_end;
  } placement_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  left_code;
    logic [CODE_BITS-1:0]  right_code;
    logic [CODE_BITS-1:0]  above_code;
    logic [CODE_BITS-1:0]  below_code;
    logic [LIGHT_BITS-1:0] light;
  } tile_entry_t;

  typedef struct {
    logic [CFG_DATA_BITS-1:0] tiles;
    logic [CFG_DATA_BITS-1:0] width;
    logic [CFG_DATA_BITS-1:0] height;
  } grid_setting_t;

  // directed row: transaction fields, then an optional typed-in expectation
  typedef struct {
    logic [CMD_BITS-1:0]   cmd;
    logic [TILE_BITS-1:0]  idx;
    logic [CODE_BITS-1:0]  cl, cr, ca, cb;
    logic [LIGHT_BITS-1:0] light;
    logic [LIGHT_BITS-1:0] target;
    bit                    typed;
    logic [TILE_BITS-1:0]  tile;
    bit                    nm, re, ge;
  } directed_row_t;

  // ---------------------------------------------------------------- signals
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_BITS-1:0]       command = wtlp_pkg::CMD_LOAD;
  logic [TILE_BITS-1:0]      tile_index = '0;
  logic [CODE_BITS-1:0]      code_left_edge = '0;
  logic [CODE_BITS-1:0]      code_right_edge = '0;
  logic [CODE_BITS-1:0]      code_prev_row_edge = '0;
  logic [CODE_BITS-1:0]      code_next_row_edge = '0;
  logic [LIGHT_BITS-1:0]     tile_lightness = '0;
  logic [LIGHT_BITS-1:0]     target_lightness = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [TILE_BITS-1:0]      tile_choice;
  logic                      no_match;
  logic                      row_end;
  logic                      grid_end;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = wtlp_pkg::CFG_TILES_IN_USE;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  wang_tile_lightness_placer_unit dut (.*);

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------- predictor state
  tile_entry_t          tile_table   [MAX_TILES];
  logic [TILE_BITS-1:0] line_buffer  [MAX_ROW_CELLS];
  bit                   line_written [MAX_ROW_CELLS];  // guards reads of unwritten cells
  logic [TILE_BITS-1:0] left_tile = '0;
  int unsigned          cur_col = 0;
  int unsigned          cur_row = 0;
  logic [4:0]           reg_tiles_in_use = 5'd16;
  logic [8:0]           reg_tiles_per_row = 9'd256;
  logic [15:0]          reg_rows_per_grid = 16'd256;

  placement_t pending_placements [$];  // expected results, oldest first
  int         fault_count = 0;

  // idling knobs, in percent; the long hold is asked for by the stimulus
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;

  grid_setting_t phase_grid [PHASES] = '{
    '{16'd16,   16'd4,    16'd3},
    '{16'd1,    16'd1,    16'd1},     // single-cell grid, one tile
    '{16'd0,    16'd5,    16'd2},     // no tiles in use: all no_match
    '{16'hFFFF, 16'd0,    16'd0},     // tile count saturates, zero sizes act as 1
    '{16'd16,   16'hFFFF, 16'hFFFF},  // width saturates, tallest grid
    '{16'd7,    16'd3,    16'd4},     // narrower than current column
    '{16'd12,   16'd256,  16'd2},
    '{16'd9,    16'd6,    16'd5}
  };

  // small grid for the directed part: 3 x 2 cells, tiles 0..3
  directed_row_t directed_rows [17] = '{
    // cmd, idx, L, R, A, B, tile_light, target, typed, tile, nm, re, ge
    '{wtlp_pkg::CMD_LOAD, 4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_LOAD, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 16'hFFFF, 16'h0000, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_LOAD, 4'd2, 4'd1, 4'd0, 4'd2, 4'd0, 16'h0001, 16'h0000, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_LOAD, 4'd3, 4'd15, 4'd14, 4'd15, 4'd15, 16'h8000, 16'h0000,
      0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_LOAD, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 16'hFFFF, 16'h0000,
      0, 4'd0, 0, 0, 0},
    // unused command: ignored, nothing comes back
    '{CMD_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 0, 4'd0, 0, 0, 0},
    // origin: no neighbour tests, exact lightness hit
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF, 1, 4'd1, 0, 0, 0},
    // equal distance to tiles 1 and 2: lower index wins
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h8000, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0},
    // last cell of the grid, position wraps
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h1234, 0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h8000, 1, 4'd3, 0, 0, 0},
    // right code 14 of tile 3 fits no left code: flagged, tile 0
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF, 1, 4'd0, 1, 0, 0},
    '{wtlp_pkg::CMD_RESTART, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000,
      0, 4'd0, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF, 1, 4'd1, 0, 0, 0},
    '{wtlp_pkg::CMD_PLACE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0}
  };

  // -------------------------------------------------------------- predictor
  function automatic void note_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      wtlp_pkg::CFG_TILES_IN_USE:  reg_tiles_in_use = data[4:0];
      wtlp_pkg::CFG_TILES_PER_ROW: reg_tiles_per_row = data[8:0];
      wtlp_pkg::CFG_ROWS_PER_GRID: reg_rows_per_grid = data[15:0];
      default: ;
    endcase
  endfunction

  // Applies one accepted transaction to the shadow state; a place transaction
  // yields the tile choice and flags the block should return.
  function automatic void predict_transaction(input tile_txn_t t,
                                              output bit makes_result,
                                              output placement_t res);
    int unsigned          n_tiles, width, height, col;
    logic [CODE_BITS-1:0] want_left, want_above;
    logic [LIGHT_BITS-1:0] gap_to_target, best_gap;
    logic [TILE_BITS-1:0] best;
    bit                   found, at_row_end, at_grid_end;

    makes_result = 1'b0;
    res = '0;
    case (t.cmd)
      wtlp_pkg::CMD_LOAD:
        tile_table[t.tile_index] = '{t.left_code, t.right_code, t.above_code,
                                     t.below_code, t.tile_light};
      wtlp_pkg::CMD_RESTART: begin
        cur_col = 0;
        cur_row = 0;
      end
      wtlp_pkg::CMD_PLACE: begin
        n_tiles = (reg_tiles_in_use > MAX_TILES) ? MAX_TILES : reg_tiles_in_use;
        width = (reg_tiles_per_row == 0) ? 1 : reg_tiles_per_row;
        if (width > MAX_ROW_CELLS) width = MAX_ROW_CELLS;
        height = (reg_rows_per_grid == 0) ? 1 : reg_rows_per_grid;
        col = (cur_col < MAX_ROW_CELLS) ? cur_col : MAX_ROW_CELLS - 1;
        want_left = (cur_col != 0) ? tile_table[left_tile].right_code : '0;
        want_above = (cur_row != 0) ? tile_table[line_buffer[col]].below_code : '0;
        found = 1'b0;
        best = '0;
        best_gap = '0;
        for (int i = 0; i < n_tiles; i++) begin
          if (cur_col != 0 && tile_table[i].left_code != want_left) continue;
          if (cur_row != 0 && tile_table[i].above_code != want_above) continue;
          gap_to_target = (t.target >= tile_table[i].light) ?
                          t.target - tile_table[i].light : tile_table[i].light - t.target;
          if (!found || gap_to_target < best_gap) begin
            found = 1'b1;
            best_gap = gap_to_target;
            best = i[TILE_BITS-1:0];
          end
        end
        line_buffer[col] = best;
        line_written[col] = 1'b1;
        left_tile = best;
        at_row_end = (cur_col + 1 >= width);
        at_grid_end = at_row_end && (cur_row + 1 >= height);
        if (at_row_end) begin
          cur_col = 0;
          cur_row = at_grid_end ? 0 : cur_row + 1;
        end else begin
          cur_col++;
        end
        makes_result = 1'b1;
        res = '{best, !found, at_row_end, at_grid_end};
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------- stimulus
  // Mostly codes 0 and 1 so that tiles chain; now and then any code.
  function automatic logic [CODE_BITS-1:0] pick_code();
    return ($urandom_range(99) < 75) ? CODE_BITS'($urandom_range(1))
                                     : CODE_BITS'($urandom);
  endfunction

  function automatic logic [LIGHT_BITS-1:0] pick_light();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return LIGHT_BITS'($urandom);
  endfunction

  function automatic tile_txn_t random_transaction();
    tile_txn_t   t;
    int unsigned roll;
    roll = $urandom_range(99);
    t.tile_index = TILE_BITS'($urandom);
    t.left_code = pick_code();
    t.right_code = pick_code();
    t.above_code = pick_code();
    t.below_code = pick_code();
    t.tile_light = pick_light();
    t.target = pick_light();
    if (roll < 70) t.cmd = wtlp_pkg::CMD_PLACE;
    else if (roll < 88) t.cmd = wtlp_pkg::CMD_LOAD;
    else if (roll < 95) t.cmd = wtlp_pkg::CMD_RESTART;
    else t.cmd = CMD_UNUSED;
    return t;
  endfunction

  // Holds the transaction on the input until accepted, then books its result.
  task automatic send_transaction(input tile_txn_t t, input bit typed,
                                  input placement_t typed_result);
    bit         makes_result;
    placement_t predicted;
    in_valid <= 1'b1;
    command <= t.cmd;
    tile_index <= t.tile_index;
    code_left_edge <= t.left_code;
    code_right_edge <= t.right_code;
    code_prev_row_edge <= t.above_code;
    code_next_row_edge <= t.below_code;
    tile_lightness <= t.tile_light;
    target_lightness <= t.target;
    do @(posedge clk); while (!in_ready);
    predict_transaction(t, makes_result, predicted);
    if (typed) predicted = typed_result;
    if (makes_result)
      pending_placements = {pending_placements, predicted};
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Waits until every booked result has come back, then lets the block
  // settle before the registers move.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_placements.size() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes all three registers and the spare index, one per cycle.
  task automatic program_grid(input grid_setting_t g);
    logic [CFG_INDEX_BITS-1:0] idx [4];
    logic [CFG_DATA_BITS-1:0]  val [4];
    idx = '{wtlp_pkg::CFG_TILES_IN_USE, wtlp_pkg::CFG_TILES_PER_ROW,
            wtlp_pkg::CFG_ROWS_PER_GRID, CFG_UNUSED};
    val = '{g.tiles, g.width, g.height, CFG_DATA_BITS'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      note_reg_write(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  // ------------------------------------------------------------ main flow
  initial begin
    tile_txn_t  t;
    placement_t want;
    int         counted;
    bit         paused;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, tables loaded before any place reads them
    program_grid('{16'd4, 16'd3, 16'd2});
    foreach (directed_rows[i]) begin
      t = '{directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].cl,
            directed_rows[i].cr, directed_rows[i].ca, directed_rows[i].cb,
            directed_rows[i].light, directed_rows[i].target};
      want = '{directed_rows[i].tile, directed_rows[i].nm, directed_rows[i].re,
               directed_rows[i].ge};
      send_transaction(t, directed_rows[i].typed, want);
      sender_gap();
    end

    // random phases; the idling pattern cycles through its four modes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      program_grid(phase_grid[p]);

      // every table entry gets written before the first random place transaction
      if (p == 0) begin
        for (int i = 0; i < MAX_TILES; i++) begin
          t = random_transaction();
          t.cmd = wtlp_pkg::CMD_LOAD;
          t.tile_index = i[TILE_BITS-1:0];
          send_transaction(t, 1'b0, '0);
        end
      end

      // output backs up while the input keeps offering transactions
      if (p == 2) long_hold_req = 1'b1;

      counted = 0;
      paused = 1'b0;
      while (counted < ITEMS_A_PHASE) begin
        t = random_transaction();
        // a line-buffer cell never written must not be read: start over instead
        if (t.cmd == wtlp_pkg::CMD_PLACE && cur_row != 0 &&
            !line_written[(cur_col < MAX_ROW_CELLS) ? cur_col : MAX_ROW_CELLS - 1]) begin
          send_transaction('{wtlp_pkg::CMD_RESTART, t.tile_index, t.left_code,
                             t.right_code, t.above_code, t.below_code,
                             t.tile_light, t.target},
                           1'b0, '0);
          counted++;
        end
        send_transaction(t, 1'b0, '0);
        if (t.cmd != CMD_UNUSED) counted++;

        // sender goes quiet until the block has handed everything back
        if (p == 4 && !paused && counted >= ITEMS_A_PHASE / 2) begin
          paused = 1'b1;
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_placements.size() != 0);
        end else begin
          sender_gap();
        end
      end
    end

    settle();
    if (fault_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // -------------------------------------------------------------- checking
  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  // every result transaction is matched against the oldest booked placement
  always @(posedge clk) begin
    placement_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{tile_choice, no_match, row_end, grid_end};
      if (pending_placements.size() == 0) begin
        log_fault($sformatf({"result with none expected: tile %0d no_match %0b ",
                             "row_end %0b grid_end %0b"},
                            got.tile, got.no_match, got.row_end, got.grid_end));
      end else begin
        want = pending_placements.pop_front();
        if (got !== want)
          log_fault($sformatf({"mismatch: tile %0d/%0d no_match %0b/%0b row_end %0b/%0b ",
                               "grid_end %0b/%0b (expected/actual)"},
                              want.tile, got.tile, want.no_match, got.no_match,
                              want.row_end, got.row_end, want.grid_end, got.grid_end));
      end
    end
  end

  // hang guard, many times the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
